// ===== design/sync_tlv_frame_parser_fletcher8_defines.svh =====
// Assertion macros used by the checker file tlvf_checker.sv.
`ifndef SYNC_TLV_FRAME_PARSER_FLETCHER8_DEFINES_SVH
`define SYNC_TLV_FRAME_PARSER_FLETCHER8_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define TLVF_ASSERT_NOW(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error("tlvf assertion failed");

// Next-cycle implication, sampled on clk, off while in reset.
`define TLVF_ASSERT_NEXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error("tlvf assertion failed");

`endif

// ===== design/tlvf_pkg.sv =====
package tlvf_pkg;

  localparam logic [7:0] SYNC_FIRST        = 8'h59;
  localparam logic [7:0] SYNC_SECOND       = 8'h53;
  localparam logic [8:0] HEADER_BYTES      = 9'd5;
  localparam logic [7:0] MAX_PAYLOAD_RESET = 8'd249;

  typedef enum logic [2:0] {
    ST_NONE       = 3'd0,
    ST_VALUE      = 3'd1,
    ST_GOOD       = 3'd2,
    ST_CHECK_BAD  = 3'd3,
    ST_TOO_LONG   = 3'd4,
    ST_STRUCT_BAD = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    PH_ID    = 2'd0,
    PH_LEN   = 2'd1,
    PH_VALUE = 2'd2
  } phase_t;

  // input register contents handed to the parse core
  typedef struct packed {
    logic       valid;
    logic [7:0] rx_byte;
  } stage_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  data_byte;
    logic [7:0]  record_id;
    logic [7:0]  record_length;
    logic [7:0]  value_index;
    logic [15:0] frame_tag;
    logic [7:0]  frame_length;
  } result_t;

endpackage

// ===== design/tlvf_ifs.sv =====
interface tlvf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface tlvf_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [7:0]  data_byte;
  logic [7:0]  record_id;
  logic [7:0]  record_length;
  logic [7:0]  value_index;
  logic [15:0] frame_tag;
  logic [7:0]  frame_length;

  modport source (output valid, output status, output data_byte, output record_id,
                  output record_length, output value_index, output frame_tag,
                  output frame_length, input ready);
  modport sink   (input valid, input status, input data_byte, input record_id,
                  input record_length, input value_index, input frame_tag,
                  input frame_length, output ready);
endinterface

// ===== design/tlvf_in_reg.sv =====
module tlvf_in_reg (
  input  logic             clk,
  input  logic             rst_n,
  tlvf_in_if.sink          in_ch,
  input  logic             advance,
  output tlvf_pkg::stage_t stage
);
  import tlvf_pkg::*;

  logic       valid_r, valid_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic       take;

  assign in_ch.ready = !valid_r || advance;
  assign take        = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    byte_nxt  = byte_r;
    if (take) begin
      valid_nxt = 1'b1;
      byte_nxt  = in_ch.rx_byte;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

  assign stage.valid   = valid_r;
  assign stage.rx_byte = byte_r;

endmodule

// ===== design/tlvf_core.sv =====
module tlvf_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        rx_byte,
  input  logic [7:0]        max_payload,
  output tlvf_pkg::result_t result
);
  import tlvf_pkg::*;

  logic [7:0]  last_byte_r, last_byte_nxt;
  logic [8:0]  bc_r, bc_nxt;
  logic [7:0]  plen_r, plen_nxt;
  logic [15:0] tag_r, tag_nxt;
  logic [7:0]  sa_r, sa_nxt;
  logic [7:0]  sb_r, sb_nxt;
  logic        fco_r, fco_nxt;
  phase_t      phase_r, phase_nxt;
  logic [7:0]  id_r, id_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [7:0]  pos_r, pos_nxt;
  logic        sbad_r, sbad_nxt;

  logic       is_hunt, is_tag_lo, is_tag_hi, is_len, is_payload, is_check1;
  logic       too_long;
  logic [8:0] payload_end;
  logic [8:0] offset;
  logic [7:0] left, left_m1;
  logic [7:0] sa_add, sb_add;
  logic [7:0] pos_inc;

  // byte position decode
  always_comb begin
    payload_end = HEADER_BYTES + {1'b0, plen_r};
    offset      = bc_r - HEADER_BYTES;
    left        = plen_r - offset[7:0];
    left_m1     = left - 8'd1;
    is_hunt     = (bc_r == 9'd0);
    is_tag_lo   = (bc_r == 9'd2);
    is_tag_hi   = (bc_r == 9'd3);
    is_len      = (bc_r == 9'd4);
    is_payload  = (bc_r >= HEADER_BYTES) && (bc_r < payload_end);
    is_check1   = (bc_r == payload_end);
    too_long    = rx_byte > max_payload;
    sa_add      = sa_r + rx_byte;
    sb_add      = sb_r + sa_add;
    pos_inc     = pos_r + 8'd1;
  end

  // next state
  always_comb begin
    last_byte_nxt = last_byte_r;
    bc_nxt        = bc_r;
    plen_nxt      = plen_r;
    tag_nxt       = tag_r;
    sa_nxt        = sa_r;
    sb_nxt        = sb_r;
    fco_nxt       = fco_r;
    phase_nxt     = phase_r;
    id_nxt        = id_r;
    len_nxt       = len_r;
    pos_nxt       = pos_r;
    sbad_nxt      = sbad_r;
    if (step) begin
      if (is_hunt) begin
        last_byte_nxt = rx_byte;
        if (last_byte_r == SYNC_FIRST && rx_byte == SYNC_SECOND) begin
          bc_nxt    = 9'd2;
          sa_nxt    = 8'd0;
          sb_nxt    = 8'd0;
          fco_nxt   = 1'b0;
          phase_nxt = PH_ID;
          id_nxt    = 8'd0;
          len_nxt   = 8'd0;
          pos_nxt   = 8'd0;
          sbad_nxt  = 1'b0;
          tag_nxt   = 16'd0;
          plen_nxt  = 8'd0;
        end
      end else if (is_tag_lo) begin
        tag_nxt[7:0] = rx_byte;
        sa_nxt       = sa_add;
        sb_nxt       = sb_add;
        bc_nxt       = 9'd3;
      end else if (is_tag_hi) begin
        tag_nxt[15:8] = rx_byte;
        sa_nxt        = sa_add;
        sb_nxt        = sb_add;
        bc_nxt        = 9'd4;
      end else if (is_len) begin
        sa_nxt = sa_add;
        sb_nxt = sb_add;
        if (too_long) begin
          bc_nxt = 9'd0;
        end else begin
          plen_nxt = rx_byte;
          bc_nxt   = HEADER_BYTES;
        end
      end else if (is_payload) begin
        sa_nxt = sa_add;
        sb_nxt = sb_add;
        bc_nxt = bc_r + 9'd1;
        if (!sbad_r) begin
          case (phase_r)
            PH_ID: begin
              if (left < 8'd2) begin
                sbad_nxt = 1'b1;
              end else begin
                id_nxt    = rx_byte;
                phase_nxt = PH_LEN;
              end
            end
            PH_LEN: begin
              if (rx_byte > left_m1) begin
                sbad_nxt = 1'b1;
              end else begin
                len_nxt   = rx_byte;
                pos_nxt   = 8'd0;
                phase_nxt = (rx_byte == 8'd0) ? PH_ID : PH_VALUE;
              end
            end
            PH_VALUE: begin
              pos_nxt = pos_inc;
              if (pos_inc == len_r) begin
                phase_nxt = PH_ID;
              end
            end
            default: begin
              phase_nxt = PH_ID;
            end
          endcase
        end
      end else if (is_check1) begin
        fco_nxt = (rx_byte == sa_r);
        bc_nxt  = bc_r + 9'd1;
      end else begin
        bc_nxt = 9'd0;
      end
    end
  end

  // result for the byte in the input register
  always_comb begin
    result = '0;
    result.status = ST_NONE;
    if (is_hunt) begin
      result.status = ST_NONE;
    end else if (is_len) begin
      if (too_long) begin
        result.status       = ST_TOO_LONG;
        result.frame_tag    = tag_r;
        result.frame_length = rx_byte;
      end
    end else if (is_payload) begin
      if (!sbad_r && phase_r == PH_VALUE) begin
        result.status        = ST_VALUE;
        result.data_byte     = rx_byte;
        result.record_id     = id_r;
        result.record_length = len_r;
        result.value_index   = pos_r;
      end
    end else if (!is_tag_lo && !is_tag_hi && !is_check1) begin
      if (!(fco_r && rx_byte == sb_r)) begin
        result.status = ST_CHECK_BAD;
      end else if (sbad_r) begin
        result.status = ST_STRUCT_BAD;
      end else begin
        result.status = ST_GOOD;
      end
      result.frame_tag    = tag_r;
      result.frame_length = plen_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_byte_r <= 8'd0;
      bc_r        <= 9'd0;
      plen_r      <= 8'd0;
      tag_r       <= 16'd0;
      sa_r        <= 8'd0;
      sb_r        <= 8'd0;
      fco_r       <= 1'b0;
      phase_r     <= PH_ID;
      id_r        <= 8'd0;
      len_r       <= 8'd0;
      pos_r       <= 8'd0;
      sbad_r      <= 1'b0;
    end else begin
      last_byte_r <= last_byte_nxt;
      bc_r        <= bc_nxt;
      plen_r      <= plen_nxt;
      tag_r       <= tag_nxt;
      sa_r        <= sa_nxt;
      sb_r        <= sb_nxt;
      fco_r       <= fco_nxt;
      phase_r     <= phase_nxt;
      id_r        <= id_nxt;
      len_r       <= len_nxt;
      pos_r       <= pos_nxt;
      sbad_r      <= sbad_nxt;
    end
  end

endmodule

// ===== design/tlvf_out_reg.sv =====
module tlvf_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  tlvf_pkg::result_t result,
  output logic              advance,
  tlvf_out_if.source        out_ch
);
  import tlvf_pkg::*;

  logic    valid_r, valid_nxt;
  result_t res_r, res_nxt;

  assign advance = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    res_nxt   = res_r;
    if (load) begin
      valid_nxt = 1'b1;
      res_nxt   = result;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_ch.valid         = valid_r;
  assign out_ch.status        = res_r.status;
  assign out_ch.data_byte     = res_r.data_byte;
  assign out_ch.record_id     = res_r.record_id;
  assign out_ch.record_length = res_r.record_length;
  assign out_ch.value_index   = res_r.value_index;
  assign out_ch.frame_tag     = res_r.frame_tag;
  assign out_ch.frame_length  = res_r.frame_length;

endmodule

// ===== design/sync_tlv_frame_parser_fletcher8.sv =====
// Sync-framed TLV parser with 8-bit Fletcher check.
// in_ch  : one received word (rx_byte) per handshake, valid/ready.
// out_ch : exactly one result word per input word, in order: status plus
//          record value fields (status 1) or frame verdict fields (2..5).
// cfg_we/cfg_data : writes max_payload (reset 249); write only while idle.
// Throughput: one word per cycle while out_ch is ready. The parser state
//   update is a single pass of add/compare logic between the input register
//   and the output register, so a new word is taken each cycle unless stalled.
// Path: an accepted word waits in the input register, passes the parse core
//   and is registered in the output register, from which out_ch offers it.
// Stall: while out_ch is held off, the input register keeps one word and
//   in_ch.ready drops only once both registers are full; nothing is lost.
// Reset (rst_n low, synchronous): both registers empty, parser hunting for
//   the sync pair with cleared window and sums, max_payload back to 249.
module sync_tlv_frame_parser_fletcher8 (
  input  logic       clk,
  input  logic       rst_n,
  tlvf_in_if.sink    in_ch,
  tlvf_out_if.source out_ch,
  input  logic       cfg_we,
  input  logic [7:0] cfg_data
);
  import tlvf_pkg::*;

  logic [7:0] max_payload_r, max_payload_nxt;
  stage_t     stage;
  result_t    result;
  logic       advance;
  logic       step;

  // max_payload is sampled by the core only when the length word passes
  always_comb begin
    max_payload_nxt = cfg_we ? cfg_data : max_payload_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_r <= MAX_PAYLOAD_RESET;
    end else begin
      max_payload_r <= max_payload_nxt;
    end
  end

  // word moves from input register to output register
  assign step = stage.valid && advance;

  tlvf_in_reg u_in_reg (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .advance (advance),
    .stage   (stage)
  );

  tlvf_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .rx_byte     (stage.rx_byte),
    .max_payload (max_payload_r),
    .result      (result)
  );

  tlvf_out_reg u_out_reg (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (step),
    .result  (result),
    .advance (advance),
    .out_ch  (out_ch)
  );

endmodule

// ===== design/tlvf_checker.sv =====
`include "sync_tlv_frame_parser_fletcher8_defines.svh"

module tlvf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  status,
  input logic [7:0]  data_byte,
  input logic [7:0]  record_id,
  input logic [7:0]  record_length,
  input logic [7:0]  value_index,
  input logic [15:0] frame_tag,
  input logic [7:0]  frame_length
);
  import tlvf_pkg::*;

  // stalled result word holds
  `TLVF_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(frame_tag) && $stable(data_byte))

  `TLVF_ASSERT_NOW(a_status_range, out_valid, status <= 3'(ST_STRUCT_BAD))

  `TLVF_ASSERT_NOW(a_value_fields, out_valid && status == 3'(ST_VALUE), value_index < record_length && frame_tag == 16'd0 && frame_length == 8'd0)

  `TLVF_ASSERT_NOW(a_record_clear, out_valid && status != 3'(ST_VALUE), data_byte == 8'd0 && record_id == 8'd0 && record_length == 8'd0 && value_index == 8'd0)

endmodule

bind sync_tlv_frame_parser_fletcher8 tlvf_checker u_tlvf_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .status        (out_ch.status),
  .data_byte     (out_ch.data_byte),
  .record_id     (out_ch.record_id),
  .record_length (out_ch.record_length),
  .value_index   (out_ch.value_index),
  .frame_tag     (out_ch.frame_tag),
  .frame_length  (out_ch.frame_length)
);

// ===== dv/tb_sync_tlv_frame_parser_fletcher8.sv =====
`timescale 1ns / 100ps

module tb_sync_tlv_frame_parser_fletcher8;
  import tlvf_pkg::*;

  // Hard stop.
  localparam int unsigned CYCLE_LIMIT = 200000;
  // Frame corruption choices for the frame builder.
  localparam int NO_FLAW    = 0;
  localparam int FLAW_SUM_A = 1;
  localparam int FLAW_SUM_B = 2;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [7:0] cfg_data;

  tlvf_in_if  in_ch ();
  tlvf_out_if out_ch ();

  sync_tlv_frame_parser_fletcher8 i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  // Words waiting to be offered, and reports the parser owes us, oldest first.
  logic [7:0]  rx_stream[$];
  result_t     owed_reports[$];

  // Handshake pacing, in percent of cycles spent idle / stalled.
  int unsigned send_gap_pct = 0;
  int unsigned recv_gap_pct = 0;
  logic        in_took = 1'b0;

  int unsigned words_queued = 0;
  int unsigned words_in = 0;
  int unsigned results_checked = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned status_seen[0:7] = '{default: 0};

  // Parser mirror: register copy plus frame and record-walk state.
  logic [7:0]  lim    = MAX_PAYLOAD_RESET;
  logic [15:0] win    = '0;
  logic [8:0]  pos    = '0;   // 0 while hunting for the sync pair
  logic [7:0]  plen   = '0;
  logic [15:0] ftag   = '0;
  logic [7:0]  fa     = '0;
  logic [7:0]  fb     = '0;
  logic        ck0_ok = 1'b0;
  phase_t      rphase = PH_ID;
  logic [7:0]  rid    = '0;
  logic [7:0]  rlen   = '0;
  logic [7:0]  vpos   = '0;
  logic        sbad   = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void fletcher_add(input logic [7:0] b);
    fa = fa + b;
    fb = fb + fa;
  endfunction

  // Advance the mirror by one received word and return the report it owes.
  function automatic result_t parse_byte(input logic [7:0] b);
    result_t    r;
    logic [8:0] left;
    r = '0;
    if (pos == 9'd0) begin
      // Window only moves while hunting, so it still holds the pair after a frame.
      win = {win[7:0], b};
      if (win == {SYNC_FIRST, SYNC_SECOND}) begin
        pos    = 9'd2;
        fa     = '0;
        fb     = '0;
        ck0_ok = 1'b0;
        rphase = PH_ID;
        rid    = '0;
        rlen   = '0;
        vpos   = '0;
        sbad   = 1'b0;
        ftag   = '0;
        plen   = '0;
      end
      return r;
    end
    if (pos == 9'd2) begin
      ftag[7:0] = b;
      fletcher_add(b);
      pos = 9'd3;
    end else if (pos == 9'd3) begin
      ftag[15:8] = b;
      fletcher_add(b);
      pos = 9'd4;
    end else if (pos == 9'd4) begin
      fletcher_add(b);
      if (b > lim) begin
        // over-long frame: abort at once, back to hunting
        pos            = 9'd0;
        r.status       = ST_TOO_LONG;
        r.frame_tag    = ftag;
        r.frame_length = b;
      end else begin
        plen = b;
        pos  = HEADER_BYTES;
      end
    end else if (pos < HEADER_BYTES + plen) begin
      fletcher_add(b);
      if (!sbad) begin
        left = {1'b0, plen} - (pos - HEADER_BYTES);   // this word included
        case (rphase)
          PH_ID: begin
            if (left < 9'd2) sbad = 1'b1;             // id with no room for a length
            else begin
              rid    = b;
              rphase = PH_LEN;
            end
          end
          PH_LEN: begin
            if ({1'b0, b} > left - 9'd1) sbad = 1'b1; // record runs past the frame
            else begin
              rlen   = b;
              vpos   = '0;
              rphase = (b == 8'd0) ? PH_ID : PH_VALUE;
            end
          end
          default: begin
            r.status        = ST_VALUE;
            r.data_byte     = b;
            r.record_id     = rid;
            r.record_length = rlen;
            r.value_index   = vpos;
            vpos = vpos + 8'd1;
            if (vpos == rlen) rphase = PH_ID;
          end
        endcase
      end
      pos = pos + 9'd1;
    end else if (pos == HEADER_BYTES + plen) begin
      ck0_ok = (b == fa);
      pos    = pos + 9'd1;
    end else begin
      // checksum verdict outranks structure
      pos = 9'd0;
      if (!(ck0_ok && b == fb)) r.status = ST_CHECK_BAD;
      else if (sbad)            r.status = ST_STRUCT_BAD;
      else                      r.status = ST_GOOD;
      r.frame_tag    = ftag;
      r.frame_length = plen;
    end
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input logic [15:0] got,
                               input logic [15:0] want);
    mismatches++;
    if (mismatches <= 100)
      $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  function automatic void queue_word(input logic [7:0] w);
    rx_stream.push_back(w);
    words_queued++;
  endfunction

  // Sync pair, tag, length, payload and the two Fletcher bytes, optionally spoilt.
  function automatic void push_frame(input logic [15:0] tag, input logic [7:0] body[$],
                                     input int flaw);
    logic [7:0] s1, s2;
    logic [7:0] covered[$];
    s1 = '0;
    s2 = '0;
    covered = {tag[7:0], tag[15:8], 8'(body.size()), body};
    queue_word(SYNC_FIRST);
    queue_word(SYNC_SECOND);
    foreach (covered[i]) begin
      s1 = s1 + covered[i];
      s2 = s2 + s1;
      queue_word(covered[i]);
    end
    if (flaw == FLAW_SUM_A) s1 = s1 ^ 8'($urandom_range(1, 255));
    if (flaw == FLAW_SUM_B) s2 = s2 ^ 8'($urandom_range(1, 255));
    queue_word(s1);
    queue_word(s2);
  endfunction

  // Mostly well-formed frames with random content; some noise, bad sums,
  // overruns, dangling ids and over-long headers mixed in.
  task automatic random_traffic(input int unsigned n_words);
    int unsigned base, pick, len, room, rl;
    logic [15:0] tag;
    logic [7:0]  body[$];
    base = words_queued;
    while (words_queued - base < n_words) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        repeat ($urandom_range(1, 4))
          queue_word(($urandom_range(3) == 0) ? SYNC_FIRST : 8'($urandom));
      end else begin
        tag  = 16'($urandom);
        pick = $urandom_range(99);
        if (pick < 70)      len = $urandom_range(0, 12);
        else if (pick < 92) len = $urandom_range(13, 40);
        else if (pick < 94) len = lim;
        else if (pick < 96) len = 8'(lim + 8'd1);
        else                len = $urandom_range(41, 255);
        if (len > lim) begin
          queue_word(SYNC_FIRST);
          queue_word(SYNC_SECOND);
          queue_word(tag[7:0]);
          queue_word(tag[15:8]);
          queue_word(8'(len));
        end else begin
          body.delete();
          if ($urandom_range(4) == 0) begin
            repeat (len) body.push_back(8'($urandom));
          end else begin
            while (body.size() < len) begin
              room = len - body.size();
              if (room < 2) begin
                body.push_back(8'($urandom));          // dangling id
              end else begin
                if ($urandom_range(15) == 0)     rl = room - 1;   // overrun by one
                else if ($urandom_range(3) == 0) rl = room - 2;   // fill to the end
                else rl = $urandom_range(0, (room - 2 < 6) ? room - 2 : 6);
                body.push_back(8'($urandom));
                body.push_back(8'(rl));
                // value words never run past the declared payload length
                repeat ((rl > room - 2) ? room - 2 : rl) body.push_back(8'($urandom));
              end
            end
          end
          pick = $urandom_range(19);
          push_frame(tag, body,
                     (pick == 0) ? FLAW_SUM_A : (pick == 1) ? FLAW_SUM_B : NO_FLAW);
        end
      end
    end
  endtask

  // Let everything queued go through and every report come back.
  task automatic settle();
    while (rx_stream.size() != 0 || in_ch.valid || owed_reports.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_max_payload(input logic [7:0] v);
    settle();
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  // Sender: a new word only once the previous one went through.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_took) begin
      if (rx_stream.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        in_ch.valid   <= 1'b1;
        in_ch.rx_byte <= rx_stream.pop_front();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure.
  always @(negedge clk)
    out_ch.ready <= rst_n && ($urandom_range(99) >= recv_gap_pct);

  // Monitor: mirror accepted words, check accepted results in order.
  always @(posedge clk) begin : watch
    result_t want;
    if (!rst_n) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_ch.valid && in_ch.ready;
      if (cfg_we) lim = cfg_data;
      if (in_ch.valid && in_ch.ready) begin
        owed_reports.push_back(parse_byte(in_ch.rx_byte));
        words_in++;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (owed_reports.size() == 0) begin
          flag_mismatch("result with nothing owed, status", out_ch.status, '0);
        end else begin
          want = owed_reports.pop_front();
          if (out_ch.status !== want.status)
            flag_mismatch("status", out_ch.status, want.status);
          if (out_ch.data_byte !== want.data_byte)
            flag_mismatch("data_byte", out_ch.data_byte, want.data_byte);
          if (out_ch.record_id !== want.record_id)
            flag_mismatch("record_id", out_ch.record_id, want.record_id);
          if (out_ch.record_length !== want.record_length)
            flag_mismatch("record_length", out_ch.record_length, want.record_length);
          if (out_ch.value_index !== want.value_index)
            flag_mismatch("value_index", out_ch.value_index, want.value_index);
          if (out_ch.frame_tag !== want.frame_tag)
            flag_mismatch("frame_tag", out_ch.frame_tag, want.frame_tag);
          if (out_ch.frame_length !== want.frame_length)
            flag_mismatch("frame_length", out_ch.frame_length, want.frame_length);
          status_seen[want.status]++;
          results_checked++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d reports still owed", cycles,
               owed_reports.size());
      $display("sync_tlv_frame_parser_fletcher8 verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    logic [7:0] body[$];
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_data      = '0;
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = '0;
    out_ch.ready  = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Sender mostly busy, receiver stalling a lot.
    send_gap_pct = 9;
    recv_gap_pct = 63;

    // Directed frames at the reset limit of 249.
    body = {8'h07, 8'h01, 8'hAA};
    push_frame(16'h1234, body, NO_FLAW);      // one record, one value word, good
    queue_word(SYNC_SECOND);                  // stale window: must not resync
    body = {8'h03, 8'h00, 8'h09};
    push_frame(16'hFFFF, body, NO_FLAW);      // zero-length record, then dangling id
    body = {8'h01, 8'h05};
    push_frame(16'h0000, body, FLAW_SUM_B);   // overrun plus bad sum: sum verdict
    body.delete();
    push_frame(16'h8001, body, NO_FLAW);      // empty payload
    queue_word(SYNC_FIRST);
    queue_word(SYNC_SECOND);
    queue_word(8'h00);
    queue_word(8'hFF);
    queue_word(8'hFA);                        // one above the limit

    random_traffic(150);
    set_max_payload(8'd0);
    random_traffic(60);
    set_max_payload(8'd255);
    random_traffic(150);

    // Other way round.
    settle();
    send_gap_pct = 63;
    recv_gap_pct = 9;
    set_max_payload(8'($urandom_range(16, 60)));
    random_traffic(220);

    // Back to back, no idling either side.
    settle();
    send_gap_pct = 0;
    recv_gap_pct = 0;
    set_max_payload(8'd5);
    random_traffic(100);
    set_max_payload(8'd200);
    random_traffic(120);

    settle();
    repeat (10) @(posedge clk);
    $display("%0d words in, %0d results checked across six max_payload values and three pacing mixes",
             words_in, results_checked);
    $display("frames: %0d good, %0d bad sum, %0d too long, %0d bad structure; %0d value words",
             status_seen[ST_GOOD], status_seen[ST_CHECK_BAD], status_seen[ST_TOO_LONG],
             status_seen[ST_STRUCT_BAD], status_seen[ST_VALUE]);
    if (mismatches == 0)
      $display("sync_tlv_frame_parser_fletcher8 verification clean");
    else
      $display("sync_tlv_frame_parser_fletcher8 verification failed");
    $finish;
  end

endmodule
